/* src/lfps_pkg.sv */
// shared widths, constants, register indexes and the configuration struct
// for the line follower pd steering block; no dependencies
package lfps_pkg;

    // field widths
    localparam int COUNT_WIDTH    = 24;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int SETPOINT_W     = 7;
    localparam int REFLECT_W      = 7;
    localparam int GAIN_W         = 10;
    localparam int POWER_W        = 8;
    localparam int LIMIT_W        = 24;
    localparam int CURVE_W        = 8;
    localparam int OUT_PWR_W      = 10;

    // internal arithmetic widths
    localparam int ERR_W   = 8;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int ACC_W   = 21;
    localparam int GAIN_CNT_W = $clog2(GAIN_W);

    localparam int CURVE_LIMIT = 100;
    localparam int MIX_DIVISOR = 50;
    localparam int MAG_CURVE_W = $clog2(CURVE_LIMIT + 1);
    localparam int MAG_POWER_W = POWER_W;
    localparam int PROD_W      = $clog2(CURVE_LIMIT * (1 << (POWER_W - 1)) + 1);
    localparam int REM_W       = $clog2(MIX_DIVISOR);
    localparam int QUO_W       = PROD_W - $clog2(MIX_DIVISOR) + 1;
    localparam int MD_CNT_W    = $clog2(PROD_W);

    // distance: halves are summed over the wider of the count and the limit
    localparam int SUM_W      = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam int DIST_CNT_W = $clog2(SUM_W + 1);

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P_GAIN      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_D_GAIN      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_POWER = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIST_LIMIT  = 3'd4;

    localparam logic [SETPOINT_W-1:0]     RST_SETPOINT    = 7'd50;
    localparam logic [GAIN_W-1:0]         RST_P_GAIN      = 10'd33;
    localparam logic [GAIN_W-1:0]         RST_D_GAIN      = 10'd13;
    localparam logic signed [POWER_W-1:0] RST_DRIVE_POWER = 8'sd30;
    localparam logic [LIMIT_W-1:0]        RST_DIST_LIMIT  = 24'd2830;

    typedef struct packed {
        logic [SETPOINT_W-1:0]     setpoint;
        logic [GAIN_W-1:0]         p_gain;
        logic [GAIN_W-1:0]         d_gain;
        logic signed [POWER_W-1:0] drive_power;
        logic [LIMIT_W-1:0]        dist_limit;
    } lfps_cfg_t;

endpackage

/* src/line_follow_pd_steer.sv */
// line follower pd steering: top level with sequencer and output register
// depends on lfps_pkg, lfps_regs, lfps_mac, lfps_mixdiv, lfps_dist
//
// one input word per control tick (restart, reflect, left and right encoder
// counts) gives one result word (left and right power, steer curve, reached).
// both channels are valid/ready; configuration sits behind an apb port at
// byte addresses 0, 4, 8, 12 and 16, and the user is to write it only while
// the block is idle; the block itself does not enforce this.
// from acceptance to the result on m_valid, the gain products run one gain
// bit per cycle until their registered done flag is seen, the curve is formed
// in the curve state, the inner wheel reduction multiplies one curve bit per
// cycle and divides one quotient bit per cycle, and the result is registered.
// the distance compare runs bit-serially alongside the gain work.
// a new item is taken once the previous one has left the arithmetic, so the
// block cannot take a new item while one is still in the arithmetic.
// when the receiver stalls, the finished word waits in the output register,
// the next word is still accepted and computed, and it waits in the last
// step until the output register is free.
// reset (synchronous, active low) restores the register defaults, clears the
// stored previous error and drops m_valid.
module line_follow_pd_steer import lfps_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    input  logic [REFLECT_W-1:0]          s_reflect,
    input  logic signed [COUNT_WIDTH-1:0] s_left_count,
    input  logic signed [COUNT_WIDTH-1:0] s_right_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_PWR_W-1:0]   m_left_power,
    output logic signed [OUT_PWR_W-1:0]   m_right_power,
    output logic signed [CURVE_W-1:0]     m_steer_curve,
    output logic                          m_reached,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_GAIN  = 4'b0010,
        ST_CURVE = 4'b0100,
        ST_MIX   = 4'b1000
    } lfps_state_t;

    localparam logic signed [ACC_W-1:0]     ACC_ZERO  = '0;
    localparam logic signed [ACC_W-1:0]     ROUND_ADJ = ACC_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [ACC_W-1:0]     CURVE_MAX = ACC_W'(CURVE_LIMIT);
    localparam logic signed [ACC_W-1:0]     CURVE_MIN = ACC_W'(-CURVE_LIMIT);
    localparam logic signed [OUT_PWR_W-1:0] PWR_ZERO  = '0;

    lfps_cfg_t                   cfg;
    lfps_state_t                 state_reg, state_next;
    logic signed [ERR_W-1:0]     last_err_reg;
    logic signed [CURVE_W-1:0]   curve_reg, curve_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [OUT_PWR_W-1:0] lp_reg, rp_reg, lp_next, rp_next;
    logic signed [CURVE_W-1:0]   mcurve_reg;
    logic                        reached_reg;

    logic                        accept, load_out;
    logic signed [ERR_W-1:0]     error, prev;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [ACC_W-1:0]     acc, acc_adj, curve_wide;
    logic                        mac_done, mix_done, dist_done, dist_reached;
    logic                        mac_start, mix_start;
    logic signed [OUT_PWR_W-1:0] reduce, pwr;
    logic                        curve_pos, curve_neg;

    lfps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign mac_start = accept;
    assign mix_start = (state_reg == ST_CURVE);

    assign error = $signed(ERR_W'(cfg.setpoint) - ERR_W'(s_reflect));
    assign prev  = s_restart ? $signed(ERR_W'(0)) : last_err_reg;
    assign diff  = DIFF_W'(error) - DIFF_W'(prev);

    lfps_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .error   (error),
        .diff    (diff),
        .p_gain  (cfg.p_gain),
        .d_gain  (cfg.d_gain),
        .acc     (acc),
        .done    (mac_done)
    );

    lfps_dist u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .left_count  (s_left_count),
        .right_count (s_right_count),
        .limit       (cfg.dist_limit),
        .reached     (dist_reached),
        .done        (dist_done)
    );

    // the reduction unit takes the curve as it is being registered
    lfps_mixdiv u_mixdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .curve   (curve_next),
        .power   (cfg.drive_power),
        .reduce  (reduce),
        .done    (mix_done)
    );

    // truncate toward zero, then clamp
    assign acc_adj    = acc + ((acc < ACC_ZERO) ? ROUND_ADJ : ACC_ZERO);
    assign curve_wide = acc_adj >>> GAIN_FRAC_BITS;

    always_comb begin
        if (curve_wide > CURVE_MAX) begin
            curve_next = CURVE_W'(CURVE_MAX);
        end else if (curve_wide < CURVE_MIN) begin
            curve_next = CURVE_W'(CURVE_MIN);
        end else begin
            curve_next = curve_wide[CURVE_W-1:0];
        end
    end

    assign pwr       = OUT_PWR_W'(cfg.drive_power);
    assign curve_neg = curve_reg[CURVE_W-1];
    assign curve_pos = ~curve_reg[CURVE_W-1] & (curve_reg != '0);
    assign rp_next   = pwr - (curve_pos ? reduce : PWR_ZERO);
    assign lp_next   = -pwr - (curve_neg ? reduce : PWR_ZERO);

    assign load_out = (state_reg == ST_MIX) & mix_done & dist_done
                      & (~m_valid_reg | m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept)   state_next = ST_GAIN;
            ST_GAIN:  if (mac_done) state_next = ST_CURVE;
            ST_CURVE: state_next = ST_MIX;
            ST_MIX:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            last_err_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                last_err_reg <= error;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CURVE) begin
            curve_reg <= curve_next;
        end
        if (load_out) begin
            mcurve_reg  <= curve_reg;
            reached_reg <= dist_reached;
            lp_reg      <= dist_reached ? PWR_ZERO : lp_next;
            rp_reg      <= dist_reached ? PWR_ZERO : rp_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_power  = lp_reg;
    assign m_right_power = rp_reg;
    assign m_steer_curve = mcurve_reg;
    assign m_reached     = reached_reg;

endmodule

/* src/lfps_regs.sv */
// apb register file holding the five steering configuration registers
// depends on lfps_pkg
module lfps_regs import lfps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output lfps_cfg_t             cfg
);

    lfps_cfg_t             cfg_reg;
    logic [REG_IDX_W-1:0]  idx;
    logic                  wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint    <= RST_SETPOINT;
            cfg_reg.p_gain      <= RST_P_GAIN;
            cfg_reg.d_gain      <= RST_D_GAIN;
            cfg_reg.drive_power <= RST_DRIVE_POWER;
            cfg_reg.dist_limit  <= RST_DIST_LIMIT;
        end else if (wr_en) begin
            case (idx)
                REG_SETPOINT:    cfg_reg.setpoint    <= pwdata[SETPOINT_W-1:0];
                REG_P_GAIN:      cfg_reg.p_gain      <= pwdata[GAIN_W-1:0];
                REG_D_GAIN:      cfg_reg.d_gain      <= pwdata[GAIN_W-1:0];
                REG_DRIVE_POWER: cfg_reg.drive_power <= $signed(pwdata[POWER_W-1:0]);
                REG_DIST_LIMIT:  cfg_reg.dist_limit  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SETPOINT:    prdata = APB_DATA_W'(cfg_reg.setpoint);
            REG_P_GAIN:      prdata = APB_DATA_W'(cfg_reg.p_gain);
            REG_D_GAIN:      prdata = APB_DATA_W'(cfg_reg.d_gain);
            REG_DRIVE_POWER: prdata = APB_DATA_W'(cfg_reg.drive_power);
            REG_DIST_LIMIT:  prdata = APB_DATA_W'(cfg_reg.dist_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

/* src/lfps_mac.sv */
// serial gain unit: p_gain*error + d_gain*diff, one bit of each gain per cycle
// depends on lfps_pkg
module lfps_mac import lfps_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [ERR_W-1:0]  error,
    input  logic signed [DIFF_W-1:0] diff,
    input  logic [GAIN_W-1:0]        p_gain,
    input  logic [GAIN_W-1:0]        d_gain,
    output logic signed [ACC_W-1:0]  acc,
    output logic                     done
);

    localparam logic signed [ACC_W-1:0]  ACC_ZERO = '0;
    localparam logic [GAIN_CNT_W-1:0]    CNT_LAST = GAIN_CNT_W'(GAIN_W - 1);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] err_sh_reg, diff_sh_reg;
    logic [GAIN_W-1:0]       pg_reg, dg_reg;
    logic [GAIN_CNT_W-1:0]   cnt_reg;
    logic                    busy_reg, done_reg;

    assign acc_next = acc_reg + (pg_reg[0] ? err_sh_reg : ACC_ZERO)
                              + (dg_reg[0] ? diff_sh_reg : ACC_ZERO);
    assign acc  = acc_reg;
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg     <= ACC_ZERO;
            err_sh_reg  <= ACC_W'(error);
            diff_sh_reg <= ACC_W'(diff);
            pg_reg      <= p_gain;
            dg_reg      <= d_gain;
        end else if (busy_reg) begin
            acc_reg     <= acc_next;
            err_sh_reg  <= err_sh_reg <<< 1;
            diff_sh_reg <= diff_sh_reg <<< 1;
            pg_reg      <= pg_reg >> 1;
            dg_reg      <= dg_reg >> 1;
        end
    end

endmodule

/* src/lfps_mixdiv.sv */
// inner wheel reduction: serial |curve|*|power| shift-add, then restoring
// division by the mix divisor one quotient bit per cycle; depends on lfps_pkg
module lfps_mixdiv import lfps_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [CURVE_W-1:0]   curve,
    input  logic signed [POWER_W-1:0]   power,
    output logic signed [OUT_PWR_W-1:0] reduce,
    output logic                        done
);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    localparam logic [MD_CNT_W-1:0] MUL_LAST = MD_CNT_W'(MAG_CURVE_W - 1);
    localparam logic [MD_CNT_W-1:0] DIV_LAST = MD_CNT_W'(PROD_W - 1);
    localparam logic [REM_W:0]      DIVISOR  = (REM_W + 1)'(MIX_DIVISOR);

    md_state_t               state_reg, state_next;
    logic [MD_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    logic [PROD_W-1:0]       work_reg, work_next;
    logic [PROD_W-1:0]       mcand_reg;
    logic [MAG_CURVE_W-1:0]  mplier_reg;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic                    neg_reg;
    logic [CURVE_W-1:0]      curve_abs;
    logic [MAG_POWER_W-1:0]  power_abs;
    logic [REM_W:0]          trial;
    logic                    fits;
    logic [REM_W:0]          trial_sub;
    logic [OUT_PWR_W-1:0]    quo_ext;

    assign curve_abs = curve[CURVE_W-1] ? CURVE_W'(-curve) : CURVE_W'(curve);
    assign power_abs = power[POWER_W-1] ? MAG_POWER_W'(-power) : MAG_POWER_W'(power);
    assign trial     = {rem_reg, work_reg[PROD_W-1]};
    assign fits      = trial >= DIVISOR;
    assign trial_sub = trial - DIVISOR;
    assign quo_ext   = OUT_PWR_W'(work_reg[QUO_W-1:0]);
    assign reduce    = neg_reg ? $signed(-quo_ext) : $signed(quo_ext);
    assign done      = done_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    state_next = MD_MUL;
                    cnt_next   = '0;
                    done_next  = 1'b0;
                    work_next  = '0;
                end
            end
            MD_MUL: begin
                work_next = work_reg + (mplier_reg[0] ? mcand_reg : '0);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = MD_DIV;
                    cnt_next   = '0;
                    rem_next   = '0;
                end
            end
            MD_DIV: begin
                // quotient bits shift in at the bottom as dividend bits leave the top
                rem_next  = fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
                work_next = {work_reg[PROD_W-2:0], fits};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = MD_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        if (state_reg == MD_IDLE && start) begin
            mcand_reg  <= PROD_W'(power_abs);
            mplier_reg <= curve_abs[MAG_CURVE_W-1:0];
            neg_reg    <= curve[CURVE_W-1] ^ power[POWER_W-1];
        end else if (state_reg == MD_MUL) begin
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

endmodule

/* src/lfps_dist.sv */
// bit-serial travelled distance: |left/2| + |right/2| compared with the limit,
// lsb first with abs, add and subtract carries; depends on lfps_pkg
module lfps_dist import lfps_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [COUNT_WIDTH-1:0] left_count,
    input  logic signed [COUNT_WIDTH-1:0] right_count,
    input  logic [LIMIT_W-1:0]            limit,
    output logic                          reached,
    output logic                          done
);

    localparam logic [DIST_CNT_W-1:0] CNT_LAST = DIST_CNT_W'(SUM_W);

    logic [SUM_W:0]          lsh_reg, rsh_reg;
    logic [SUM_W-1:0]        lim_reg;
    logic                    lneg_reg, rneg_reg;
    logic                    lc_reg, rc_reg, c_reg, bw_reg;
    logic [DIST_CNT_W-1:0]   cnt_reg;
    logic                    busy_reg, done_reg, reached_reg;
    logic                    la, ra, lc_next, rc_next;
    logic                    s, c_next, bw_next;

    // two's complement magnitude, one bit per cycle
    assign la      = lneg_reg ? (~lsh_reg[0] ^ lc_reg) : lsh_reg[0];
    assign ra      = rneg_reg ? (~rsh_reg[0] ^ rc_reg) : rsh_reg[0];
    assign lc_next = ~lsh_reg[0] & lc_reg;
    assign rc_next = ~rsh_reg[0] & rc_reg;

    assign s       = la ^ ra ^ c_reg;
    assign c_next  = (la & ra) | (c_reg & (la ^ ra));
    assign bw_next = (~s & lim_reg[0]) | (~(s ^ lim_reg[0]) & bw_reg);

    assign reached = reached_reg;
    assign done    = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lsh_reg  <= (SUM_W + 1)'(left_count);
            rsh_reg  <= (SUM_W + 1)'(right_count);
            lneg_reg <= left_count[COUNT_WIDTH-1];
            rneg_reg <= right_count[COUNT_WIDTH-1];
            lim_reg  <= SUM_W'(limit);
            lc_reg   <= 1'b1;
            rc_reg   <= 1'b1;
            c_reg    <= 1'b0;
            bw_reg   <= 1'b0;
        end else if (busy_reg) begin
            lsh_reg <= lsh_reg >> 1;
            rsh_reg <= rsh_reg >> 1;
            lc_reg  <= lc_next;
            rc_reg  <= rc_next;
            // the first magnitude bit is the one halving drops
            if (cnt_reg != '0) begin
                c_reg   <= c_next;
                bw_reg  <= bw_next;
                lim_reg <= lim_reg >> 1;
            end
            if (cnt_reg == CNT_LAST) begin
                reached_reg <= c_next | ~bw_next;
            end
        end
    end

endmodule

/* src/lfps_checker.sv */
// port-level checks on the steering result channel, bound to the top level
// depends on lfps_pkg
module lfps_checker import lfps_pkg::*; (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [OUT_PWR_W-1:0] m_left_power,
    input logic signed [OUT_PWR_W-1:0] m_right_power,
    input logic signed [CURVE_W-1:0]   m_steer_curve,
    input logic                        m_reached
);

    localparam logic signed [CURVE_W-1:0] CURVE_HI = CURVE_W'(CURVE_LIMIT);
    localparam logic signed [CURVE_W-1:0] CURVE_LO = CURVE_W'(-CURVE_LIMIT);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_power)
            && $stable(m_right_power) && $stable(m_steer_curve) && $stable(m_reached))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reached |-> m_left_power == '0 && m_right_power == '0)
        else $error("motors not stopped with distance reached");

    a_curve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_steer_curve <= CURVE_HI && m_steer_curve >= CURVE_LO)
        else $error("steer curve out of range");

    // straight ahead drives both wheels equally, left mounted inverted
    a_straight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reached && m_steer_curve == '0 |-> m_left_power == -m_right_power)
        else $error("straight mix not symmetric");

endmodule

bind line_follow_pd_steer lfps_checker u_lfps_checker (.*);

/* test/tb_line_follow_pd_steer.sv */
// self-checking testbench for line_follow_pd_steer: pd steering and motor mix
// depends on lfps_pkg and the rtl under src; reads no files, needs no arguments
module tb_line_follow_pd_steer;
    import lfps_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 600;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

    typedef struct packed {
        logic                          restart;
        logic [REFLECT_W-1:0]          reflect;
        logic signed [COUNT_WIDTH-1:0] left_count;
        logic signed [COUNT_WIDTH-1:0] right_count;
    } tick_t;

    typedef struct packed {
        logic signed [OUT_PWR_W-1:0] left_power;
        logic signed [OUT_PWR_W-1:0] right_power;
        logic signed [CURVE_W-1:0]   steer_curve;
        logic                        reached;
    } steer_word_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic                          s_restart     = 1'b0;
    logic [REFLECT_W-1:0]          s_reflect     = '0;
    logic signed [COUNT_WIDTH-1:0] s_left_count  = '0;
    logic signed [COUNT_WIDTH-1:0] s_right_count = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic signed [OUT_PWR_W-1:0]   m_left_power;
    logic signed [OUT_PWR_W-1:0]   m_right_power;
    logic signed [CURVE_W-1:0]     m_steer_curve;
    logic                          m_reached;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]         paddr   = '0;
    logic [APB_DATA_W-1:0]         pwdata  = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;

    line_follow_pd_steer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .s_reflect     (s_reflect),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_power  (m_left_power),
        .m_right_power (m_right_power),
        .m_steer_curve (m_steer_curve),
        .m_reached     (m_reached),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    // controller copy: configuration and previous error
    lfps_cfg_t                 model_cfg;
    logic signed [ERR_W-1:0]   last_err;

    tick_t       pending_ticks[$];
    steer_word_t expected_words[$];
    tick_t       held_tick;
    steer_word_t want;
    steer_word_t got;

    bit idle_on        = 1'b1;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int words_seen     = 0;
    int fail_count     = 0;
    int mismatch_count = 0;

    function automatic steer_word_t next_steer_word(input tick_t t);
        int err;
        int prev;
        int acc;
        int curve;
        int pwr;
        int lp;
        int rp;
        longint lhalf;
        longint rhalf;
        longint travel;
        steer_word_t r;
        err   = int'(model_cfg.setpoint) - int'(t.reflect);
        prev  = t.restart ? 0 : int'(last_err);
        acc   = int'(model_cfg.p_gain) * err + int'(model_cfg.d_gain) * (err - prev);
        curve = acc / (1 << GAIN_FRAC_BITS);
        if (curve > CURVE_LIMIT)
            curve = CURVE_LIMIT;
        if (curve < -CURVE_LIMIT)
            curve = -CURVE_LIMIT;
        last_err = err[ERR_W-1:0];

        // inner wheel slows down, left motor is mounted reversed
        pwr = int'(model_cfg.drive_power);
        rp  = pwr;
        lp  = -pwr;
        if (curve < 0)
            lp = -pwr - (curve * pwr) / MIX_DIVISOR;
        else if (curve > 0)
            rp = pwr - (curve * pwr) / MIX_DIVISOR;

        lhalf  = longint'(t.left_count) / 2;
        rhalf  = longint'(t.right_count) / 2;
        travel = (lhalf < 0 ? -lhalf : lhalf) + (rhalf < 0 ? -rhalf : rhalf);
        r.reached = (travel >= longint'(model_cfg.dist_limit));
        if (r.reached) begin
            lp = 0;
            rp = 0;
        end
        r.left_power  = lp[OUT_PWR_W-1:0];
        r.right_power = rp[OUT_PWR_W-1:0];
        r.steer_curve = curve[CURVE_W-1:0];
        return r;
    endfunction

    // sender: at random leaves idle gaps between words while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                expected_words.push_back(next_steer_word(held_tick));
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
                held_tick = pending_ticks.pop_front();
                s_restart     <= held_tick.restart;
                s_reflect     <= held_tick.reflect;
                s_left_count  <= held_tick.left_count;
                s_right_count <= held_tick.right_count;
                s_valid       <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 12);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // one long hold so the block fills up and stalls its input
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end else if (words_seen >= 200 && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
    end

    // receiver: checks each word against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_left_power, m_right_power, m_steer_curve, m_reached};
                words_seen = words_seen + 1;
                if (expected_words.size() == 0) begin
                    fail_count = fail_count + 1;
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected word: left %0d right %0d curve %0d reached %0b",
                                 got.left_power, got.right_power, got.steer_curve,
                                 got.reached);
                end else begin
                    want = expected_words.pop_front();
                    if (got.left_power !== want.left_power
                            || got.right_power !== want.right_power
                            || got.steer_curve !== want.steer_curve
                            || got.reached !== want.reached) begin
                        fail_count = fail_count + 1;
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("word %0d: expected left %0d right %0d curve %0d %s",
                                     words_seen, want.left_power, want.right_power,
                                     want.steer_curve,
                                     $sformatf("reached %0b, got left %0d right %0d %s",
                                               want.reached, got.left_power,
                                               got.right_power,
                                               $sformatf("curve %0d reached %0b",
                                                         got.steer_curve, got.reached)));
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SETPOINT:    model_cfg.setpoint    = value[SETPOINT_W-1:0];
            REG_P_GAIN:      model_cfg.p_gain      = value[GAIN_W-1:0];
            REG_D_GAIN:      model_cfg.d_gain      = value[GAIN_W-1:0];
            REG_DRIVE_POWER: model_cfg.drive_power = value[POWER_W-1:0];
            REG_DIST_LIMIT:  model_cfg.dist_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits may carry noise that the block must drop
    task automatic set_config(input lfps_cfg_t c);
        logic [31:0] noise;
        noise = $urandom_range(0, 1) ? $urandom() : 32'd0;
        reg_write(REG_SETPOINT,    {noise[31:SETPOINT_W], c.setpoint});
        reg_write(REG_P_GAIN,      {noise[31:GAIN_W], c.p_gain});
        reg_write(REG_D_GAIN,      {noise[31:GAIN_W], c.d_gain});
        reg_write(REG_DRIVE_POWER, {noise[31:POWER_W], c.drive_power});
        reg_write(REG_DIST_LIMIT,  {noise[31:LIMIT_W], c.dist_limit});
    endtask

    function automatic lfps_cfg_t make_cfg(input int sp, input int pg, input int dg,
                                           input int pw, input int lim);
        lfps_cfg_t c;
        c.setpoint    = sp[SETPOINT_W-1:0];
        c.p_gain      = pg[GAIN_W-1:0];
        c.d_gain      = dg[GAIN_W-1:0];
        c.drive_power = pw[POWER_W-1:0];
        c.dist_limit  = lim[LIMIT_W-1:0];
        return c;
    endfunction

    task automatic add_tick(input bit rs, input int refl, input int lc, input int rc);
        tick_t t;
        t.restart     = rs;
        t.reflect     = refl[REFLECT_W-1:0];
        t.left_count  = lc[COUNT_WIDTH-1:0];
        t.right_count = rc[COUNT_WIDTH-1:0];
        pending_ticks.push_back(t);
    endtask

    // counts spread around the stop distance, with some full-range values
    function automatic logic signed [COUNT_WIDTH-1:0] random_count();
        int span;
        int mode;
        mode = $urandom_range(0, 9);
        span = (model_cfg.dist_limit > 24'd4194300) ? 8388607
                                                     : 2 * int'(model_cfg.dist_limit) + 8;
        if (mode == 0)
            return COUNT_WIDTH'($urandom());
        if (mode == 1)
            return $urandom_range(0, 1) ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                                        : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
        return COUNT_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // mostly runs that start with restart and drive on past the limit,
    // the rest loose words with random restart
    task automatic queue_runs(input int n_items);
        tick_t t;
        int run_left;
        int lc;
        int rc;
        int refl;
        int dir_l;
        int dir_r;
        int step_max;
        run_left = 0;
        lc = 0;
        rc = 0;
        refl = 50;
        dir_l = 1;
        dir_r = 1;
        step_max = int'(model_cfg.dist_limit) / 8 + 20;
        if (step_max > 1000000)
            step_max = 1000000;
        repeat (n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                t.restart     = ($urandom_range(0, 4) == 0);
                t.reflect     = ($urandom_range(0, 7) == 0)
                                ? REFLECT_W'($urandom_range(101, 127))
                                : REFLECT_W'($urandom_range(0, 100));
                t.left_count  = random_count();
                t.right_count = random_count();
            end else begin
                if (run_left == 0) begin
                    run_left  = $urandom_range(5, 40);
                    lc        = 0;
                    rc        = 0;
                    refl      = $urandom_range(0, 100);
                    dir_l     = $urandom_range(0, 3) == 0 ? -1 : 1;
                    dir_r     = $urandom_range(0, 3) == 0 ? -1 : 1;
                    t.restart = 1'b1;
                end else begin
                    t.restart = 1'b0;
                    lc = lc + dir_l * int'($urandom_range(0, step_max));
                    rc = rc + dir_r * int'($urandom_range(0, step_max));
                    refl = refl + int'($urandom_range(0, 30)) - 15;
                    if (refl < 0)
                        refl = 0;
                    if (refl > 100)
                        refl = 100;
                end
                run_left      = run_left - 1;
                t.reflect     = refl[REFLECT_W-1:0];
                t.left_count  = lc[COUNT_WIDTH-1:0];
                t.right_count = rc[COUNT_WIDTH-1:0];
            end
            pending_ticks.push_back(t);
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || s_valid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        lfps_cfg_t c;
        model_cfg = make_cfg(RST_SETPOINT, RST_P_GAIN, RST_D_GAIN,
                             RST_DRIVE_POWER, RST_DIST_LIMIT);
        last_err = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: zero curve, sign of error, out-of-range reflect, restart
        add_tick(1, 50, 0, 0);
        add_tick(0, 0, 0, 0);
        add_tick(0, 100, 0, 0);
        add_tick(0, 127, 10, -10);
        add_tick(1, 127, 0, 0);
        add_tick(0, 0, 0, 0);
        // distance right at the limit, halves truncated toward zero
        add_tick(0, 40, 5660, 0);
        add_tick(0, 60, 5659, 0);
        add_tick(0, 45, -5661, 0);
        add_tick(0, 55, 1, -1);
        add_tick(0, 30, -8388608, 8388607);
        add_tick(0, 70, 8388607, -8388608);
        add_tick(0, 50, 2830, 2830);
        add_tick(0, 50, 2829, 2831);
        queue_runs(230);
        wait_drained();

        // strongest gains with the most negative power and no stop
        reg_write(REG_UNMAPPED, $urandom());
        set_config(make_cfg(127, 1023, 1023, -128, 16777215));
        add_tick(1, 0, 0, 0);
        add_tick(0, 127, -8388608, -8388608);
        add_tick(1, 127, 8388607, 8388607);
        add_tick(0, 0, 100, -100);
        add_tick(0, 127, 0, 0);
        queue_runs(140);
        wait_drained();

        // zero gains, limit zero: every word stops
        set_config(make_cfg(0, 0, 0, 127, 0));
        add_tick(0, 127, 0, 0);
        queue_runs(140);
        wait_drained();

        set_config(make_cfg(100, 1023, 0, 100, 4000));
        queue_runs(140);
        wait_drained();

        set_config(make_cfg(50, 0, 1023, -100, 1000));
        queue_runs(140);
        wait_drained();

        repeat (2) begin
            c.setpoint    = SETPOINT_W'($urandom_range(0, 127));
            c.p_gain      = GAIN_W'($urandom_range(0, 1023));
            c.d_gain      = GAIN_W'($urandom_range(0, 1023));
            c.drive_power = POWER_W'($urandom_range(0, 255));
            c.dist_limit  = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom())
                                                        : LIMIT_W'($urandom_range(0, 20000));
            set_config(c);
            queue_runs(140);
            wait_drained();
        end

        // last stretch at full rate on both sides
        set_config(make_cfg(60, 33, 13, -1, 2830));
        idle_on = 1'b0;
        queue_runs(150);
        wait_drained();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
